@@ rtl/jdn_pkg.sv @@
// Shared types, constants and lookup tables for the Julian day number converter.
package jdn_pkg;

    // Operation codes
    localparam logic OP_TO_JDN  = 1'b0;
    localparam logic OP_TO_DATE = 1'b1;

    // Register stages between the request port and the response register
    localparam int NUM_STAGES = 7;

    // Valid day number range: Jan 1 of year 0 through Dec 31 of year 9999
    localparam logic [22:0] JDN_MIN = 23'd1721060;
    localparam logic [22:0] JDN_MAX = 23'd5373484;

    // Reciprocal constants for exact truncating division by constants.
    // floor(x * RECIP >> SHIFT) == floor(x / D) as long as x_max * (D - 1) < 2**SHIFT.
    localparam int          DIV100_SHIFT = 19;
    localparam logic [12:0] DIV100_RECIP =
        13'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);

    localparam int          DIVN_SHIFT = 43;
    localparam logic [25:0] DIVN_RECIP =
        26'(((64'd1 << DIVN_SHIFT) + 64'd146096) / 64'd146097);

    localparam int          DIVI_SHIFT = 49;
    localparam logic [28:0] DIVI_RECIP =
        29'(((64'd1 << DIVI_SHIFT) + 64'd1461000) / 64'd1461001);

    // Divide-by-2447 reciprocal with the factor of 80 folded in
    localparam int          DIVJ_SHIFT = 29;
    localparam logic [24:0] DIVJ80_RECIP =
        25'(64'd80 * (((64'd1 << DIVJ_SHIFT) + 64'd2446) / 64'd2447));

    typedef struct packed {
        logic        operation;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [13:0] year_in;
        logic [22:0] day_number_in;
    } req_t;

    typedef struct packed {
        logic [22:0] day_number_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [13:0] year_out;
        logic        valid_res;
    } rsp_t;

    // floor(367 * m' / 12), m' being the month counted from March
    function automatic logic [8:0] month_days367(input logic [3:0] month);
        logic [8:0] v;
        case (month)
            4'd1:    v = 9'd336;
            4'd2:    v = 9'd367;
            4'd3:    v = 9'd30;
            4'd4:    v = 9'd61;
            4'd5:    v = 9'd91;
            4'd6:    v = 9'd122;
            4'd7:    v = 9'd152;
            4'd8:    v = 9'd183;
            4'd9:    v = 9'd214;
            4'd10:   v = 9'd244;
            4'd11:   v = 9'd275;
            4'd12:   v = 9'd305;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // floor(2447 * j / 80): day offset of month index j
    function automatic logic [8:0] day_offset2447(input logic [3:0] j);
        logic [8:0] v;
        case (j)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd152;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd305;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd428;
            default: v = 9'd458;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/jdn_enc.sv @@
// Date to Julian day number datapath: date check, substitution and formula.
module jdn_enc (
    input  logic                          clk,
    input  logic [jdn_pkg::NUM_STAGES:1]  adv,
    input  logic [3:0]                    month_in,
    input  logic [4:0]                    day_in,
    input  logic [13:0]                   year_in,
    output logic [22:0]                   day_number,
    output logic                          date_ok
);
    import jdn_pkg::*;

    localparam logic [3:0]  DEF_MONTH   = 4'd5;
    localparam logic [4:0]  DEF_DAY     = 5'd11;
    localparam logic [13:0] DEF_YEAR    = 14'd1959;
    localparam logic [13:0] YEAR_MAX    = 14'd9999;
    localparam logic [23:0] DATE_OFFSET = 24'd32075;

    // stage 1 signals
    logic [26:0] yq_prod;
    logic [7:0]  q100_next;
    logic [3:0]  s1_month_reg;
    logic [4:0]  s1_day_reg;
    logic [13:0] s1_year_reg;
    logic [7:0]  s1_q100_reg;

    // stage 2 signals
    logic [13:0] rem100_full;
    logic [6:0]  rem100;
    logic        leap;
    logic [4:0]  month_len;
    logic        ok_next;
    logic [3:0]  month_sel;
    logic [4:0]  day_sel;
    logic [13:0] year_sel;
    logic        early;
    logic [14:0] ya_next;
    logic [13:0] yc_next;
    logic        s2_ok_reg;
    logic [3:0]  s2_month_reg;
    logic [4:0]  s2_day_reg;
    logic [14:0] s2_ya_reg;
    logic [13:0] s2_yc_reg;

    // stage 3 signals
    logic [25:0] ya_prod;
    logic [22:0] base_next;
    logic [26:0] yc_prod;
    logic [7:0]  cent_next;
    logic        s3_ok_reg;
    logic [3:0]  s3_month_reg;
    logic [4:0]  s3_day_reg;
    logic [22:0] s3_base_reg;
    logic [7:0]  s3_cent_reg;

    // stage 4 and alignment tail
    logic [9:0]  cent3;
    logic [23:0] jdn_sum;
    logic [22:0] jdn_next;
    logic [22:0] jdn_pipe_reg [4:NUM_STAGES];
    logic [NUM_STAGES:4] ok_pipe_reg;

    // Stage 1: year / 100 for the leap rule
    assign yq_prod   = 27'(year_in) * 27'(DIV100_RECIP);
    assign q100_next = yq_prod[DIV100_SHIFT +: 8];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_month_reg <= month_in;
            s1_day_reg   <= day_in;
            s1_year_reg  <= year_in;
            s1_q100_reg  <= q100_next;
        end
    end

    // Stage 2: date check, default date substitution, March-based year
    always_comb
    begin
        rem100_full = s1_year_reg - (14'(s1_q100_reg) * 14'd100);
        rem100      = rem100_full[6:0];
        leap        = (s1_year_reg[1:0] == 2'd0) &&
                      ((rem100 != 7'd0) || (s1_q100_reg[1:0] == 2'd0));
        case (s1_month_reg)
            4'd2:                     month_len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  month_len = 5'd30;
            default:                  month_len = 5'd31;
        endcase
        ok_next = (s1_year_reg <= YEAR_MAX) &&
                  (s1_month_reg >= 4'd1) && (s1_month_reg <= 4'd12) &&
                  (s1_day_reg >= 5'd1) && (s1_day_reg <= month_len);
        month_sel = ok_next ? s1_month_reg : DEF_MONTH;
        day_sel   = ok_next ? s1_day_reg   : DEF_DAY;
        year_sel  = ok_next ? s1_year_reg  : DEF_YEAR;
        // January and February count as months of the previous year
        early   = (month_sel <= 4'd2);
        ya_next = 15'(year_sel) + 15'd4800 - 15'(early);
        yc_next = year_sel + 14'd4900 - 14'(early);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_ok_reg    <= ok_next;
            s2_month_reg <= month_sel;
            s2_day_reg   <= day_sel;
            s2_ya_reg    <= ya_next;
            s2_yc_reg    <= yc_next;
        end
    end

    // Stage 3: days of whole years, and century count
    assign ya_prod   = 26'(s2_ya_reg) * 26'd1461;
    assign base_next = ya_prod[24:2];
    assign yc_prod   = 27'(s2_yc_reg) * 27'(DIV100_RECIP);
    assign cent_next = yc_prod[DIV100_SHIFT +: 8];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_ok_reg    <= s2_ok_reg;
            s3_month_reg <= s2_month_reg;
            s3_day_reg   <= s2_day_reg;
            s3_base_reg  <= base_next;
            s3_cent_reg  <= cent_next;
        end
    end

    // Stage 4: final sum with the Gregorian century correction
    always_comb
    begin
        cent3    = 10'(s3_cent_reg) * 10'd3;
        jdn_sum  = 24'(s3_day_reg) + 24'(s3_base_reg) + 24'(month_days367(s3_month_reg))
                 - 24'(cent3[9:2]) - DATE_OFFSET;
        jdn_next = jdn_sum[22:0];
    end

    // Stage 4 register, then delay to line up with the decode path
    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            jdn_pipe_reg[4] <= jdn_next;
            ok_pipe_reg[4]  <= s3_ok_reg;
        end
        for (int s = 5; s <= NUM_STAGES; s++)
        begin
            if (adv[s])
            begin
                jdn_pipe_reg[s] <= jdn_pipe_reg[s-1];
                ok_pipe_reg[s]  <= ok_pipe_reg[s-1];
            end
        end
    end

    assign day_number = jdn_pipe_reg[NUM_STAGES];
    assign date_ok    = ok_pipe_reg[NUM_STAGES];

endmodule

@@ rtl/jdn_dec.sv @@
// Julian day number to date datapath; each constant division has a stage of its own.
module jdn_dec (
    input  logic                          clk,
    input  logic [jdn_pkg::NUM_STAGES:1]  adv,
    input  logic [22:0]                   day_number_in,
    output logic [3:0]                    month,
    output logic [4:0]                    day,
    output logic [13:0]                   year,
    output logic                          range_ok
);
    import jdn_pkg::*;

    localparam logic [23:0] JDN_BIAS   = 24'd68569;
    localparam logic [25:0] CYCLE_DAYS = 26'd146097;
    localparam logic [14:0] YEAR_BIAS  = 15'd4900;

    // stage 1
    logic [23:0] l_next;
    logic        rng_next;
    logic [23:0] s1_l_reg;
    logic        s1_rng_reg;

    // stage 2
    logic [50:0] n_prod;
    logic [7:0]  n_next;
    logic [23:0] s2_l_reg;
    logic [7:0]  s2_n_reg;
    logic        s2_rng_reg;

    // stage 3
    logic [25:0] cyc_prod;
    logic [25:0] cyc_round;
    logic [23:0] l2_full;
    logic [15:0] s3_l2_reg;
    logic [7:0]  s3_n_reg;
    logic        s3_rng_reg;

    // stage 4
    logic [27:0] x_next;
    logic [27:0] s4_x_reg;
    logic [15:0] s4_l2_reg;
    logic [7:0]  s4_n_reg;
    logic        s4_rng_reg;

    // stage 5
    logic [56:0] i_prod;
    logic [6:0]  i_next;
    logic [6:0]  s5_i_reg;
    logic [15:0] s5_l2_reg;
    logic [7:0]  s5_n_reg;
    logic        s5_rng_reg;

    // stage 6
    logic [17:0] yr4_prod;
    logic [15:0] l3_full;
    logic [14:0] yr_next;
    logic [9:0]  s6_l3_reg;
    logic [14:0] s6_yr_reg;
    logic        s6_rng_reg;

    // stage 7
    logic [34:0] j_prod;
    logic [3:0]  j_next;
    logic [3:0]  s7_j_reg;
    logic [9:0]  s7_l3_reg;
    logic [14:0] s7_yr_reg;
    logic        s7_rng_reg;

    // output step
    logic        wrap;
    logic [9:0]  day_full;
    logic [14:0] year_full;

    // Stage 1: bias and range check
    assign l_next   = 24'(day_number_in) + JDN_BIAS;
    assign rng_next = (day_number_in >= JDN_MIN) && (day_number_in <= JDN_MAX);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_l_reg   <= l_next;
            s1_rng_reg <= rng_next;
        end
    end

    // Stage 2: n = 4l / 146097 (400-year cycles)
    assign n_prod = 51'({s1_l_reg, 2'b00}) * 51'(DIVN_RECIP);
    assign n_next = n_prod[DIVN_SHIFT +: 8];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_l_reg   <= s1_l_reg;
            s2_n_reg   <= n_next;
            s2_rng_reg <= s1_rng_reg;
        end
    end

    // Stage 3: remove the whole cycles
    assign cyc_prod  = 26'(s2_n_reg) * CYCLE_DAYS;
    assign cyc_round = cyc_prod + 26'd3;
    assign l2_full   = s2_l_reg - cyc_round[25:2];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_l2_reg  <= l2_full[15:0];
            s3_n_reg   <= s2_n_reg;
            s3_rng_reg <= s2_rng_reg;
        end
    end

    // Stage 4: scale for the year-in-cycle division
    assign x_next = (28'(s3_l2_reg) + 28'd1) * 28'd4000;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_x_reg   <= x_next;
            s4_l2_reg  <= s3_l2_reg;
            s4_n_reg   <= s3_n_reg;
            s4_rng_reg <= s3_rng_reg;
        end
    end

    // Stage 5: i = 4000 (l2 + 1) / 1461001
    assign i_prod = 57'(s4_x_reg) * 57'(DIVI_RECIP);
    assign i_next = i_prod[DIVI_SHIFT +: 7];

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_i_reg   <= i_next;
            s5_l2_reg  <= s4_l2_reg;
            s5_n_reg   <= s4_n_reg;
            s5_rng_reg <= s4_rng_reg;
        end
    end

    // Stage 6: day within the March-based year, and partial year
    assign yr4_prod = 18'(s5_i_reg) * 18'd1461;
    assign l3_full  = s5_l2_reg - yr4_prod[17:2] + 16'd31;
    assign yr_next  = 15'(s5_n_reg) * 15'd100 + 15'(s5_i_reg);

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_l3_reg  <= l3_full[9:0];
            s6_yr_reg  <= yr_next;
            s6_rng_reg <= s5_rng_reg;
        end
    end

    // Stage 7: month index j = 80 l3 / 2447
    assign j_prod = 35'(s6_l3_reg) * 35'(DIVJ80_RECIP);
    assign j_next = j_prod[DIVJ_SHIFT +: 4];

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s7_j_reg   <= j_next;
            s7_l3_reg  <= s6_l3_reg;
            s7_yr_reg  <= s6_yr_reg;
            s7_rng_reg <= s6_rng_reg;
        end
    end

    // Output step: January and February roll into the next year
    always_comb
    begin
        wrap      = (s7_j_reg >= 4'd11);
        day_full  = s7_l3_reg - 10'(day_offset2447(s7_j_reg));
        year_full = s7_yr_reg + 15'(wrap) - YEAR_BIAS;
        month     = '0;
        day       = '0;
        year      = '0;
        if (s7_rng_reg)
        begin
            month = s7_j_reg + 4'd2 - (wrap ? 4'd12 : 4'd0);
            day   = day_full[4:0];
            year  = year_full[13:0];
        end
    end

    assign range_ok = s7_rng_reg;

endmodule

@@ rtl/julian_day_number_converter.sv @@
// Top level of the Julian day number converter: pipeline control and response register.
//
// Usage:
//   Requests arrive on req (req_valid / req_stall); a transaction is taken at a
//   rising edge with req_valid high and req_stall low. req.operation picks the
//   conversion: date to Julian day number, or day number back to a date.
//   Results leave on rsp (rsp_valid / rsp_stall), one per request, in order.
//   Path: a request taken on req passes seven stages of datapath registers,
//   then the response register, before it shows up on rsp.
//   Throughput: one transaction per cycle unless a stall on rsp backs up the
//   pipeline; each constant division is a reciprocal multiply that owns one
//   pipeline stage, the widest being the 28 x 29 bit multiply of the year-in-cycle division.
//   Stall: when rsp_stall holds a result, rsp stays put and the stages behind
//   it keep moving until the first occupied stage; req_stall rises only once
//   every stage is full. Nothing is dropped or repeated.
//   Reset: rst_n clears all stage valid bits and rsp_valid; the data and operation
//   code registers are not reset, and the block is ready for a request right after reset.
module julian_day_number_converter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  jdn_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output jdn_pkg::rsp_t  rsp
);
    import jdn_pkg::*;

    logic [NUM_STAGES:1]   vld_reg;
    logic [NUM_STAGES:1]   op_reg;
    logic [NUM_STAGES+1:1] rdy;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    logic [22:0] enc_jdn;
    logic        enc_ok;
    logic [3:0]  dec_month;
    logic [4:0]  dec_day;
    logic [13:0] dec_year;
    logic        dec_ok;

    // Ready chain: a stage loads when empty or when the one after it moves
    always_comb
    begin
        rdy[NUM_STAGES+1] = !rsp_valid_reg || !rsp_stall;
        for (int s = NUM_STAGES; s >= 1; s--)
        begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    end

    assign req_stall = !rdy[1];

    // Stage valid bits and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy[1])
            begin
                vld_reg[1] <= req_valid;
            end
            for (int s = 2; s <= NUM_STAGES; s++)
            begin
                if (rdy[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
            if (rdy[NUM_STAGES+1])
            begin
                rsp_valid_reg <= vld_reg[NUM_STAGES];
            end
        end
    end

    // Operation code travels alongside the data
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            op_reg[1] <= req.operation;
        end
        for (int s = 2; s <= NUM_STAGES; s++)
        begin
            if (rdy[s])
            begin
                op_reg[s] <= op_reg[s-1];
            end
        end
    end

    jdn_enc u_enc (
        .clk        (clk),
        .adv        (rdy[NUM_STAGES:1]),
        .month_in   (req.month_in),
        .day_in     (req.day_in),
        .year_in    (req.year_in),
        .day_number (enc_jdn),
        .date_ok    (enc_ok)
    );

    jdn_dec u_dec (
        .clk           (clk),
        .adv           (rdy[NUM_STAGES:1]),
        .day_number_in (req.day_number_in),
        .month         (dec_month),
        .day           (dec_day),
        .year          (dec_year),
        .range_ok      (dec_ok)
    );

    // Result select; the fields of the other conversion read as zero
    always_comb
    begin
        rsp_next = '0;
        if (op_reg[NUM_STAGES] == OP_TO_JDN)
        begin
            rsp_next.day_number_out = enc_jdn;
            rsp_next.valid_res      = enc_ok;
        end
        else
        begin
            rsp_next.month_out = dec_month;
            rsp_next.day_out   = dec_day;
            rsp_next.year_out  = dec_year;
            rsp_next.valid_res = dec_ok;
        end
    end

    // Response register
    always_ff @(posedge clk)
    begin
        if (rdy[NUM_STAGES+1])
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/jdn_chk.sv @@
// Port-level checker for the Julian day number converter, with its bind.
module jdn_chk (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  jdn_pkg::rsp_t  rsp
);
    import jdn_pkg::*;

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // With the output free, a transaction comes out on rsp after passing every pipeline stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
            ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
        |=> rsp_valid)
        else $error("response missing after pipeline latency");

    // Only one conversion's fields carry data
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.day_number_out == 23'd0) ||
                      (rsp.month_out == 4'd0 && rsp.day_out == 5'd0 &&
                       rsp.year_out == 14'd0))
        else $error("both conversions present in one response");

    // Day numbers stay in range; decoded dates are well formed
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |->
            ((rsp.day_number_out != 23'd0) &&
             (rsp.day_number_out >= JDN_MIN) && (rsp.day_number_out <= JDN_MAX)) ||
            ((rsp.day_number_out == 23'd0) && !rsp.valid_res) ||
            ((rsp.day_number_out == 23'd0) &&
             (rsp.month_out >= 4'd1) && (rsp.month_out <= 4'd12) &&
             (rsp.day_out >= 5'd1) && (rsp.year_out <= 14'd9999)))
        else $error("response field out of range");

endmodule

bind julian_day_number_converter jdn_chk u_jdn_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
